@@ rtl/i2c_master_bit_engine_top_assert.svh @@
`ifndef I2C_MASTER_BIT_ENGINE_TOP_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_TOP_ASSERT_SVH

// property that must hold on every sampled edge outside reset
`define MBE_ASSERT_HOLD(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent in a cycle implies consequent in the next
`define MBE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/i2c_mbe_pkg.sv @@
package i2c_mbe_pkg;

   localparam int COUNT_WIDTH_DEF = 16;
   localparam int HP_W            = 16;
   localparam logic [HP_W-1:0] HALF_PERIOD_RESET = 16'd250;

   localparam logic [2:0] REQ_TICK  = 3'd0;
   localparam logic [2:0] REQ_START = 3'd1;
   localparam logic [2:0] REQ_STOP  = 3'd2;
   localparam logic [2:0] REQ_WRITE = 3'd3;
   localparam logic [2:0] REQ_READ  = 3'd4;

   localparam logic [3:0] BYTE_BITS = 4'd8;
   localparam logic [3:0] LAST_BIT  = 4'd9;

   typedef enum logic [4:0] {
      PH_IDLE, PH_RS_D1, PH_RS_ST, PH_RS_D2, PH_S_CHECK, PH_S_D,
      PH_P_D1, PH_P_ST, PH_P_D2, PH_P_CHECK, PH_P_D3,
      PH_WB_D1, PH_WB_ST, PH_WB_D2, PH_RB_D1, PH_RB_ST, PH_RB_D2
   } phase_type;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] tx_byte;
      logic       send_nack;
      logic       scl_in;
      logic       sda_in;
   } req_beat_type;

   typedef struct packed {
      logic       scl_drive_low;
      logic       sda_drive_low;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       nack_seen;
      logic       arb_lost;
   } rsp_beat_type;

endpackage

@@ rtl/i2c_mbe_core.sv @@
module i2c_mbe_core
   import i2c_mbe_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  req_beat_type      item,
   input  logic [HP_W-1:0]   half_period,
   output rsp_beat_type      result
);

   localparam int LIM_W = (COUNT_WIDTH > HP_W) ? COUNT_WIDTH : HP_W;

   phase_type              phase_ff, phase_in;
   logic [3:0]             bit_count_ff, bit_count_in;
   logic [7:0]             shift_ff, shift_in;
   logic [COUNT_WIDTH-1:0] wait_ff, wait_in;
   logic                   in_transfer_ff, in_transfer_in;
   logic                   ack_hold_ff, ack_hold_in;
   logic                   scl_low_ff, scl_low_in;
   logic                   sda_low_ff, sda_low_in;
   logic                   nack_ff, nack_in;
   logic                   arb_ff, arb_in;
   logic [7:0]             rx_ff, rx_in;
   logic                   done;

   logic [LIM_W-1:0]       lim;
   logic [LIM_W-1:0]       cnt_max;
   logic [COUNT_WIDTH-1:0] wait_inc;
   logic                   hit;
   logic                   is_tick;
   logic [3:0]             bit_next;
   logic                   last_bit;
   logic                   bit_open;

   // zero acts as one, beyond counter range clamps to counter max
   always_comb begin
      cnt_max = LIM_W'({COUNT_WIDTH{1'b1}});
      lim = LIM_W'(half_period);
      if (lim == '0) begin
         lim = LIM_W'(1);
      end
      if (lim > cnt_max) begin
         lim = cnt_max;
      end
   end

   assign wait_inc = wait_ff + COUNT_WIDTH'(1);
   assign hit      = LIM_W'(wait_inc) >= lim;
   assign is_tick  = item.req_type == REQ_TICK;
   assign bit_next = bit_count_ff + 4'd1;
   assign last_bit = bit_next >= LAST_BIT;
   assign bit_open = bit_count_ff < BYTE_BITS;

   function automatic logic begin_sda_low(input logic is_write, input logic [3:0] bcnt,
                                          input logic msb, input logic ack);
      logic send;
      if (is_write) begin
         send = (bcnt < BYTE_BITS) ? msb : 1'b1;
      end else begin
         send = (bcnt < BYTE_BITS) ? 1'b1 : ack;
      end
      return !send;
   endfunction

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         if (phase_ff == PH_IDLE) begin
            case (item.req_type)
               REQ_START: begin
                  phase_in = in_transfer_ff ? PH_RS_D1 : PH_S_CHECK;
               end
               REQ_STOP:  phase_in = PH_P_D1;
               REQ_WRITE: phase_in = PH_WB_D1;
               REQ_READ:  phase_in = PH_RB_D1;
               default:   phase_in = phase_ff;
            endcase
         end else if (is_tick) begin
            case (phase_ff)
               PH_RS_D1:   if (hit) phase_in = PH_RS_ST;
               PH_RS_ST:   if (item.scl_in) phase_in = PH_RS_D2;
               PH_RS_D2:   if (hit) phase_in = PH_S_D;
               PH_S_CHECK: phase_in = PH_S_D;
               PH_S_D:     if (hit) phase_in = PH_IDLE;
               PH_P_D1:    if (hit) phase_in = PH_P_ST;
               PH_P_ST:    if (item.scl_in) phase_in = PH_P_D2;
               PH_P_D2:    if (hit) phase_in = PH_P_CHECK;
               PH_P_CHECK: phase_in = PH_P_D3;
               PH_P_D3:    if (hit) phase_in = PH_IDLE;
               PH_WB_D1:   if (hit) phase_in = PH_WB_ST;
               PH_RB_D1:   if (hit) phase_in = PH_RB_ST;
               PH_WB_ST:   if (item.scl_in) phase_in = PH_WB_D2;
               PH_RB_ST:   if (item.scl_in) phase_in = PH_RB_D2;
               PH_WB_D2: begin
                  if (hit) phase_in = last_bit ? PH_IDLE : PH_WB_D1;
               end
               PH_RB_D2: begin
                  if (hit) phase_in = last_bit ? PH_IDLE : PH_RB_D1;
               end
               default:    phase_in = PH_IDLE;
            endcase
         end
      end
   end

   // datapath and line drives
   always_comb begin
      bit_count_in   = bit_count_ff;
      shift_in       = shift_ff;
      wait_in        = wait_ff;
      in_transfer_in = in_transfer_ff;
      ack_hold_in    = ack_hold_ff;
      scl_low_in     = scl_low_ff;
      sda_low_in     = sda_low_ff;
      nack_in        = nack_ff;
      arb_in         = arb_ff;
      rx_in          = rx_ff;
      done           = 1'b0;
      if (step) begin
         if (phase_ff == PH_IDLE) begin
            if (item.req_type == REQ_START || item.req_type == REQ_STOP ||
                item.req_type == REQ_WRITE || item.req_type == REQ_READ) begin
               arb_in       = 1'b0;
               wait_in      = '0;
               bit_count_in = '0;
            end
            case (item.req_type)
               REQ_START: sda_low_in = 1'b0;
               REQ_STOP:  sda_low_in = 1'b1;
               REQ_WRITE: begin
                  shift_in   = item.tx_byte;
                  sda_low_in = !item.tx_byte[7];
               end
               REQ_READ: begin
                  shift_in    = '0;
                  ack_hold_in = item.send_nack;
                  sda_low_in  = 1'b0;
               end
               default: ;
            endcase
         end else if (is_tick) begin
            case (phase_ff)
               PH_RS_D1, PH_P_D1, PH_WB_D1, PH_RB_D1: begin
                  wait_in = hit ? '0 : wait_inc;
                  if (hit) scl_low_in = 1'b0;
               end
               PH_RS_ST, PH_P_ST: begin
                  if (item.scl_in) wait_in = '0;
               end
               PH_RS_D2: begin
                  wait_in = hit ? '0 : wait_inc;
                  if (hit) begin
                     if (!item.sda_in) arb_in = 1'b1;
                     sda_low_in = 1'b1;
                  end
               end
               PH_S_CHECK: begin
                  if (!item.sda_in) arb_in = 1'b1;
                  sda_low_in = 1'b1;
                  wait_in    = '0;
               end
               PH_S_D: begin
                  wait_in = hit ? '0 : wait_inc;
                  if (hit) begin
                     scl_low_in     = 1'b1;
                     in_transfer_in = 1'b1;
                     done           = 1'b1;
                  end
               end
               PH_P_D2: begin
                  wait_in = hit ? '0 : wait_inc;
                  if (hit) sda_low_in = 1'b0;
               end
               PH_P_CHECK: begin
                  if (!item.sda_in) arb_in = 1'b1;
                  wait_in = '0;
               end
               PH_P_D3: begin
                  wait_in = hit ? '0 : wait_inc;
                  if (hit) begin
                     in_transfer_in = 1'b0;
                     done           = 1'b1;
                  end
               end
               PH_WB_ST: begin
                  if (item.scl_in) begin
                     if (bit_open) begin
                        if (shift_ff[7] && !item.sda_in) arb_in = 1'b1;
                        shift_in = {shift_ff[6:0], 1'b0};
                     end else begin
                        nack_in = item.sda_in;
                     end
                     wait_in = '0;
                  end
               end
               PH_RB_ST: begin
                  if (item.scl_in) begin
                     if (bit_open) begin
                        shift_in = {shift_ff[6:0], item.sda_in};
                     end else if (ack_hold_ff && !item.sda_in) begin
                        arb_in = 1'b1;
                     end
                     wait_in = '0;
                  end
               end
               PH_WB_D2, PH_RB_D2: begin
                  wait_in = hit ? '0 : wait_inc;
                  if (hit) begin
                     scl_low_in = 1'b1;
                     if (last_bit) begin
                        if (phase_ff == PH_RB_D2) rx_in = shift_ff;
                        bit_count_in = '0;
                        done         = 1'b1;
                     end else begin
                        bit_count_in = bit_next;
                        sda_low_in   = begin_sda_low(phase_ff == PH_WB_D2, bit_next,
                                                     shift_ff[7], ack_hold_ff);
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_count_ff   <= '0;
         shift_ff       <= '0;
         wait_ff        <= '0;
         in_transfer_ff <= 1'b0;
         ack_hold_ff    <= 1'b0;
         scl_low_ff     <= 1'b0;
         sda_low_ff     <= 1'b0;
         nack_ff        <= 1'b0;
         arb_ff         <= 1'b0;
         rx_ff          <= '0;
      end else begin
         phase_ff       <= phase_in;
         bit_count_ff   <= bit_count_in;
         shift_ff       <= shift_in;
         wait_ff        <= wait_in;
         in_transfer_ff <= in_transfer_in;
         ack_hold_ff    <= ack_hold_in;
         scl_low_ff     <= scl_low_in;
         sda_low_ff     <= sda_low_in;
         nack_ff        <= nack_in;
         arb_ff         <= arb_in;
         rx_ff          <= rx_in;
      end
   end

   always_comb begin
      result.scl_drive_low = scl_low_in;
      result.sda_drive_low = sda_low_in;
      result.busy_res      = phase_in != PH_IDLE;
      result.done_res      = done;
      result.rx_byte       = rx_in;
      result.nack_seen     = nack_in;
      result.arb_lost      = arb_in;
   end

endmodule

@@ rtl/i2c_master_bit_engine_top.sv @@
// I2C master bit engine: one request beat in, one response beat out.
// The response beat is registered: an accepted request beat enters the input register,
// then its phase update is written into the response register.
// Throughput: one beat per cycle while the response side does not stall; the phase update is a single pass.
// Reset (synchronous, active high): idle, both lines released, flags clear,
// half period 250 ticks.
module i2c_master_bit_engine_top
   import i2c_mbe_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_beat_type    req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_beat_type    rsp_data,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [HP_W-1:0] csr_data
);

   logic            s1_valid_ff, s1_valid_in;
   req_beat_type    s1_data_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_beat_type    rsp_data_ff;
   logic [HP_W-1:0] half_period_ff;
   logic            advance;
   logic            step;
   logic            req_take;
   rsp_beat_type    result;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign step      = s1_valid_ff && advance;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = step ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         half_period_ff <= HALF_PERIOD_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            half_period_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req_data;
      end
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   i2c_mbe_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (s1_data_ff),
      .half_period (half_period_ff),
      .result      (result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/i2c_mbe_checker.sv @@
`include "i2c_master_bit_engine_top_assert.svh"

module i2c_mbe_checker
   import i2c_mbe_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_stall,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_beat_type    rsp_data
);

   // stalled response beat holds
   `MBE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp beat changed under stall")

   // request side only backs up behind a stalled response
   `MBE_ASSERT_HOLD(a_req_stall_cause, !req_stall || (rsp_valid && rsp_stall), "req stall without rsp stall")

   // a finishing command leaves the engine idle
   `MBE_ASSERT_HOLD(a_done_idle, !rsp_valid || !(rsp_data.done_res && rsp_data.busy_res), "done while busy")

   // SDA low with SCL released never happens while the engine is idle
   `MBE_ASSERT_HOLD(a_idle_lines, !rsp_valid || rsp_data.busy_res || !(rsp_data.sda_drive_low && !rsp_data.scl_drive_low), "idle with SDA low and SCL released")

endmodule

bind i2c_master_bit_engine_top i2c_mbe_checker u_checker (.*);

@@ bench/i2c_master_bit_engine_top_tb.sv @@
`timescale 1ns / 1ps

module i2c_master_bit_engine_top_tb;
   import i2c_mbe_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int TAIL_CYCLES    = 20;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_beat_type     req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_beat_type     rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [HP_W-1:0]  csr_data  = '0;

   i2c_master_bit_engine_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // stimulus and expected line states
   req_beat_type beats_to_send[$];
   rsp_beat_type due_responses[$];
   int           beats_queued = 0;
   int           beats_taken  = 0;
   int           err_cnt      = 0;
   int           send_gap_pct = 0;
   int           recv_gap_pct = 0;
   logic         pressure_go  = 1'b0;
   logic         pressure_spent;
   int           hold_left;
   logic         req_fired;
   int           quiet_cycles;

   // engine shadow state
   phase_type        ph        = PH_IDLE;
   logic [3:0]       bit_cnt   = '0;
   logic [7:0]       shreg     = '0;
   logic [15:0]      wcnt      = '0;
   logic             open_xfer = 1'b0;
   logic             ack_hold  = 1'b0;
   logic             scl_lo    = 1'b0;
   logic             sda_lo    = 1'b0;
   logic             nack_f    = 1'b0;
   logic             arb_f     = 1'b0;
   logic [7:0]       rx_hold   = '0;
   logic [HP_W-1:0]  half_ticks = HALF_PERIOD_RESET;

   function automatic logic hp_elapsed();
      logic [15:0] lim;
      lim = (half_ticks == '0) ? 16'd1 : half_ticks;
      wcnt = wcnt + 16'd1;
      if (wcnt >= lim) begin
         wcnt = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void load_bit(logic is_write);
      logic send;
      if (is_write) begin
         send = (bit_cnt < BYTE_BITS) ? shreg[7] : 1'b1;
         ph = PH_WB_D1;
      end else begin
         send = (bit_cnt < BYTE_BITS) ? 1'b1 : ack_hold;
         ph = PH_RB_D1;
      end
      sda_lo = ~send;
      wcnt = '0;
   endfunction

   function automatic rsp_beat_type bus_engine_step(req_beat_type b);
      rsp_beat_type r;
      logic fin;
      logic wr;
      fin = 1'b0;
      if (ph == PH_IDLE) begin
         if (b.req_type >= REQ_START && b.req_type <= REQ_READ) begin
            arb_f = 1'b0;
            wcnt = '0;
            bit_cnt = '0;
            case (b.req_type)
               REQ_START: begin
                  sda_lo = 1'b0;
                  ph = open_xfer ? PH_RS_D1 : PH_S_CHECK;
               end
               REQ_STOP: begin
                  sda_lo = 1'b1;
                  ph = PH_P_D1;
               end
               REQ_WRITE: begin
                  shreg = b.tx_byte;
                  load_bit(1'b1);
               end
               default: begin
                  shreg = '0;
                  ack_hold = b.send_nack;
                  load_bit(1'b0);
               end
            endcase
         end
      end else if (b.req_type == REQ_TICK) begin
         case (ph)
            PH_RS_D1: if (hp_elapsed()) begin
               scl_lo = 1'b0;
               ph = PH_RS_ST;
            end
            PH_RS_ST: if (b.scl_in) begin
               wcnt = '0;
               ph = PH_RS_D2;
            end
            PH_RS_D2: if (hp_elapsed()) begin
               if (!b.sda_in) arb_f = 1'b1;
               sda_lo = 1'b1;
               ph = PH_S_D;
            end
            PH_S_CHECK: begin
               if (!b.sda_in) arb_f = 1'b1;
               sda_lo = 1'b1;
               wcnt = '0;
               ph = PH_S_D;
            end
            PH_S_D: if (hp_elapsed()) begin
               scl_lo = 1'b1;
               open_xfer = 1'b1;
               ph = PH_IDLE;
               fin = 1'b1;
            end
            PH_P_D1: if (hp_elapsed()) begin
               scl_lo = 1'b0;
               ph = PH_P_ST;
            end
            PH_P_ST: if (b.scl_in) begin
               wcnt = '0;
               ph = PH_P_D2;
            end
            PH_P_D2: if (hp_elapsed()) begin
               sda_lo = 1'b0;
               ph = PH_P_CHECK;
            end
            PH_P_CHECK: begin
               if (!b.sda_in) arb_f = 1'b1;
               wcnt = '0;
               ph = PH_P_D3;
            end
            PH_P_D3: if (hp_elapsed()) begin
               open_xfer = 1'b0;
               ph = PH_IDLE;
               fin = 1'b1;
            end
            PH_WB_D1, PH_RB_D1: if (hp_elapsed()) begin
               scl_lo = 1'b0;
               ph = (ph == PH_WB_D1) ? PH_WB_ST : PH_RB_ST;
            end
            PH_WB_ST: if (b.scl_in) begin
               if (bit_cnt < BYTE_BITS) begin
                  if (shreg[7] && !b.sda_in) arb_f = 1'b1;
                  shreg = {shreg[6:0], 1'b0};
               end else begin
                  nack_f = b.sda_in;
               end
               wcnt = '0;
               ph = PH_WB_D2;
            end
            PH_RB_ST: if (b.scl_in) begin
               if (bit_cnt < BYTE_BITS) shreg = {shreg[6:0], b.sda_in};
               else if (ack_hold && !b.sda_in) arb_f = 1'b1;
               wcnt = '0;
               ph = PH_RB_D2;
            end
            PH_WB_D2, PH_RB_D2: if (hp_elapsed()) begin
               wr = (ph == PH_WB_D2);
               scl_lo = 1'b1;
               bit_cnt = bit_cnt + 4'd1;
               if (bit_cnt >= LAST_BIT) begin
                  if (!wr) rx_hold = shreg;
                  bit_cnt = '0;
                  ph = PH_IDLE;
                  fin = 1'b1;
               end else begin
                  load_bit(wr);
               end
            end
            default: ph = PH_IDLE;
         endcase
      end
      r.scl_drive_low = scl_lo;
      r.sda_drive_low = sda_lo;
      r.busy_res      = (ph != PH_IDLE);
      r.done_res      = fin;
      r.rx_byte       = rx_hold;
      r.nack_seen     = nack_f;
      r.arb_lost      = arb_f;
      return r;
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else if (!req_valid || req_fired) begin
         if (beats_to_send.size() != 0 && $urandom_range(99, 0) >= send_gap_pct) begin
            req_valid <= 1'b1;
            req_data  <= beats_to_send.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      req_fired <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         due_responses.push_back(bus_engine_step(req_data));
         beats_taken <= beats_taken + 1;
      end
   end

   // response side stall, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall      <= 1'b0;
         hold_left      <= 0;
         pressure_spent <= 1'b0;
      end else if (pressure_go && !pressure_spent) begin
         pressure_spent <= 1'b1;
         hold_left      <= HOLD_CYCLES;
         rsp_stall      <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < recv_gap_pct);
      end
   end

   task automatic report_bad(input string what, input rsp_beat_type want,
                             input rsp_beat_type got);
      err_cnt++;
      if (err_cnt <= 10)
         $display("%0t %s: want scl %b sda %b busy %b done %b rx %h nack %b arb %b | got scl %b sda %b busy %b done %b rx %h nack %b arb %b",
                  $realtime, what,
                  want.scl_drive_low, want.sda_drive_low, want.busy_res, want.done_res,
                  want.rx_byte, want.nack_seen, want.arb_lost,
                  got.scl_drive_low, got.sda_drive_low, got.busy_res, got.done_res,
                  got.rx_byte, got.nack_seen, got.arb_lost);
   endtask

   // response monitor
   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_responses.size() == 0) begin
            report_bad("unexpected beat", '0, rsp_data);
         end else begin
            want = due_responses.pop_front();
            if (rsp_data.scl_drive_low !== want.scl_drive_low ||
                rsp_data.sda_drive_low !== want.sda_drive_low ||
                rsp_data.busy_res      !== want.busy_res ||
                rsp_data.done_res      !== want.done_res ||
                rsp_data.rx_byte       !== want.rx_byte ||
                rsp_data.nack_seen     !== want.nack_seen ||
                rsp_data.arb_lost      !== want.arb_lost)
               report_bad("mismatch", want, rsp_data);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_beat(input logic [2:0] req, input logic [7:0] tx, input logic nk,
                             input logic scl, input logic sda);
      req_beat_type b;
      b.req_type  = req;
      b.tx_byte   = tx;
      b.send_nack = nk;
      b.scl_in    = scl;
      b.sda_in    = sda;
      beats_to_send.push_back(b);
      beats_queued++;
   endtask

   function automatic req_beat_type pick_beat();
      req_beat_type b;
      int r;
      r = $urandom_range(99, 0);
      b.tx_byte   = 8'($urandom);
      b.send_nack = 1'($urandom);
      if (r < 3)
         b.req_type = 3'($urandom_range(7, 5));
      else if ((ph == PH_IDLE && r < 55) || r < 6)
         b.req_type = 3'($urandom_range(REQ_READ, REQ_START));
      else
         b.req_type = REQ_TICK;
      b.scl_in = ($urandom_range(99, 0) < 75);
      b.sda_in = sda_lo ? ($urandom_range(19, 0) == 0) : 1'($urandom_range(1, 0));
      return b;
   endfunction

   task automatic run_random(input int count);
      int goal;
      goal = beats_queued + count;
      while (beats_queued < goal) begin
         while (beats_to_send.size() >= 2) @(negedge clock);
         beats_to_send.push_back(pick_beat());
         beats_queued++;
         @(negedge clock);
      end
   endtask

   task automatic wait_quiet();
      while (beats_taken != beats_queued || due_responses.size() != 0) @(negedge clock);
   endtask

   task automatic set_half_period(input logic [HP_W-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      half_ticks = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_gap_pct = 18;
      recv_gap_pct = 85;
      set_half_period(16'd1);

      queue_beat(REQ_TICK,  8'h00, 1'b0, 1'b1, 1'b1);
      queue_beat(REQ_START, 8'h00, 1'b0, 1'b1, 1'b1);
      queue_beat(REQ_WRITE, 8'hFF, 1'b1, 1'b1, 1'b1);   // busy: dropped
      queue_beat(REQ_TICK,  8'h00, 1'b0, 1'b1, 1'b0);   // sda low at start check
      queue_beat(REQ_TICK,  8'h00, 1'b0, 1'b1, 1'b1);
      queue_beat(3'd5,      8'hFF, 1'b1, 1'b0, 1'b0);
      queue_beat(3'd7,      8'h00, 1'b0, 1'b1, 1'b1);
      queue_beat(REQ_START, 8'h00, 1'b0, 1'b1, 1'b1);   // repeated start
      queue_beat(REQ_TICK,  8'h00, 1'b0, 1'b1, 1'b1);
      queue_beat(REQ_TICK,  8'h00, 1'b0, 1'b0, 1'b1);   // scl stretched
      queue_beat(REQ_TICK,  8'h00, 1'b0, 1'b1, 1'b1);
      queue_beat(REQ_TICK,  8'h00, 1'b0, 1'b1, 1'b1);
      queue_beat(REQ_TICK,  8'h00, 1'b0, 1'b1, 1'b1);
      queue_beat(REQ_STOP,  8'h00, 1'b0, 1'b1, 1'b1);
      queue_beat(REQ_TICK,  8'h00, 1'b0, 1'b1, 1'b1);
      queue_beat(REQ_TICK,  8'h00, 1'b0, 1'b1, 1'b1);
      queue_beat(REQ_TICK,  8'h00, 1'b0, 1'b1, 1'b1);
      queue_beat(REQ_TICK,  8'h00, 1'b0, 1'b1, 1'b0);   // stop check sees sda low
      queue_beat(REQ_TICK,  8'h00, 1'b0, 1'b1, 1'b1);
      queue_beat(REQ_WRITE, 8'hFF, 1'b0, 1'b1, 1'b1);   // write with no start
      queue_beat(REQ_TICK,  8'h00, 1'b0, 1'b0, 1'b0);
      wait_quiet();

      run_random(250);
      wait_quiet();
      set_half_period(16'd0);
      run_random(150);

      wait_quiet();
      send_gap_pct = 85;
      recv_gap_pct = 18;
      set_half_period(16'd3);
      run_random(400);
      wait_quiet();
      set_half_period(16'hFFFF);
      run_random(120);

      wait_quiet();
      send_gap_pct = 0;
      recv_gap_pct = 0;
      set_half_period(16'd2);
      run_random(200);
      @(posedge clock);
      pressure_go = 1'b1;
      run_random(250);
      wait_quiet();
      set_half_period(16'd1);
      run_random(150);

      wait_quiet();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_cnt == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
